>>> hw/rtl/gbi_pkg.sv
// Shared constants and types of the grid bilinear interpolator.
`timescale 1ns / 1ps
package gbi_pkg;
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int AXIS_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W    = 7;
    localparam int BANK_AW  = (ROW_W - 1) + (COL_W - 1);
    localparam int BANK_N   = 4;

    typedef enum logic [2:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_Y_ORIGIN = 3'd1,
        CFG_X_SCALE  = 3'd2,
        CFG_Y_SCALE  = 3'd3,
        CFG_COLS     = 3'd4,
        CFG_ROWS     = 3'd5
    } t_cfg_idx;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              in_span;
        logic [AXIS_W-1:0] lo;
        logic [15:0]       frac;
    } t_axis;
endpackage

>>> hw/rtl/gbi_if.sv
// Valid/ready channel interfaces for query and result beats.
`timescale 1ns / 1ps
interface gbi_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] sample_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    modport source (output valid, kind, row, col, sample_value, query_x, query_y,
                    input ready);
    modport sink   (input valid, kind, row, col, sample_value, query_x, query_y,
                    output ready);
endinterface

interface gbi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interp_value;
    logic               inside_res;
    modport source (output valid, interp_value, inside_res, input ready);
    modport sink   (input valid, interp_value, inside_res, output ready);
endinterface

>>> hw/rtl/gbi_axis.sv
// Three-stage mapping of one axis from world units to cell index and fraction.
`timescale 1ns / 1ps
module gbi_axis
    import gbi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_q,
    input  logic signed [31:0] i_origin,
    input  logic [31:0]        i_scale,
    input  logic [CNT_W-1:0]   i_n,
    output t_axis              o_res
);
    localparam logic [63:0] HALF = 64'h0000_0000_8000_0000;

    logic signed [32:0] r_d;
    logic               r_pos;
    logic [63:0]        r_u;
    t_axis              r_res;
    logic [63:0]        lim;
    logic [63:0]        t;

    assign lim = (64'(i_n) << 32) - HALF;
    assign t   = r_u - HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d         <= {i_q[31], i_q} - {i_origin[31], i_origin};
            r_pos       <= !r_d[32] && (r_d != 33'sd0);
            r_u         <= 64'(r_d[31:0]) * 64'(i_scale);
            r_res.in_span <= r_pos && (r_u >= HALF) && (r_u <= lim);
            r_res.lo     <= t[32 +: AXIS_W];
            r_res.frac   <= t[31:16];
        end
    end

    assign o_res = r_res;
endmodule

>>> hw/rtl/gbi_store.sv
// Sample store split into four parity banks so one beat reads all four neighbors.
`timescale 1ns / 1ps
module gbi_store
    import gbi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_we,
    input  logic [ROW_W-1:0]   i_wrow,
    input  logic [COL_W-1:0]   i_wcol,
    input  logic [31:0]        i_wdata,
    input  logic [ROW_W-1:0]   i_r0,
    input  logic [COL_W-1:0]   i_c0,
    output logic [31:0]        o_rdata [BANK_N]
);
    localparam int DEPTH = 1 << BANK_AW;

    for (genvar b = 0; b < BANK_N; b++) begin : g_bank
        localparam logic PR = 1'((b >> 1) & 1);
        localparam logic PC = 1'(b & 1);

        logic [31:0]      mem [DEPTH];
        logic [31:0]      r_rd;
        logic [ROW_W-1:0] rsel;
        logic [COL_W-1:0] csel;
        logic [BANK_AW-1:0] raddr;
        logic [BANK_AW-1:0] waddr;
        logic             hit;

        // pick whichever of the two neighbors has this bank's parity
        assign rsel  = (i_r0[0] == PR) ? i_r0 : i_r0 + ROW_W'(1);
        assign csel  = (i_c0[0] == PC) ? i_c0 : i_c0 + COL_W'(1);
        assign raddr = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
        assign waddr = {i_wrow[ROW_W-1:1], i_wcol[COL_W-1:1]};
        assign hit   = (i_wrow[0] == PR) && (i_wcol[0] == PC);

        always_ff @(posedge i_clk) begin
            if (i_en && i_we && hit) begin
                mem[waddr] <= i_wdata;
            end
            if (i_en) begin
                r_rd <= mem[raddr];
            end
        end

        assign o_rdata[b] = r_rd;
    end
endmodule

>>> hw/rtl/gbi_blend.sv
// Weight, multiply and sum pipeline that forms the rounded bilinear blend.
`timescale 1ns / 1ps
module gbi_blend
    import gbi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_bank [BANK_N],
    input  logic               i_rpar,
    input  logic               i_cpar,
    input  logic [15:0]        i_fx,
    input  logic [15:0]        i_fy,
    output logic signed [31:0] o_value
);
    logic [16:0]        wx0, wx1, wy0, wy1;
    logic [32:0]        r_w [4];
    logic signed [31:0] r_s [4];
    logic signed [65:0] r_p [4];
    logic signed [65:0] r_sa, r_sb;
    logic signed [65:0] acc;
    logic [1:0]         i00, i01, i10, i11;

    assign wx1 = {1'b0, i_fx};
    assign wx0 = 17'h10000 - wx1;
    assign wy1 = {1'b0, i_fy};
    assign wy0 = 17'h10000 - wy1;
    assign i00 = {i_rpar, i_cpar};
    assign i01 = {i_rpar, ~i_cpar};
    assign i10 = {~i_rpar, i_cpar};
    assign i11 = {~i_rpar, ~i_cpar};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w[0] <= 33'(34'(wx0) * 34'(wy0));
            r_w[1] <= 33'(34'(wx1) * 34'(wy0));
            r_w[2] <= 33'(34'(wx0) * 34'(wy1));
            r_w[3] <= 33'(34'(wx1) * 34'(wy1));
            r_s[0] <= i_bank[i00];
            r_s[1] <= i_bank[i01];
            r_s[2] <= i_bank[i10];
            r_s[3] <= i_bank[i11];
            // a zero weight sits on the clamped-off neighbor at the upper edge
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= (r_w[k] == 33'd0) ? 66'sd0 :
                          66'($signed({1'b0, r_w[k]}) * r_s[k]);
            end
            r_sa <= r_p[0] + r_p[1];
            r_sb <= r_p[2] + r_p[3];
        end
    end

    // round half toward plus infinity
    assign acc     = r_sa + r_sb + 66'sh0_8000_0000;
    assign o_value = acc[63:32];
endmodule

>>> hw/rtl/grid_bilinear_interpolator_core.sv
// Top level of the grid bilinear interpolator.
`timescale 1ns / 1ps
// Usage:
//   i_query carries one beat per item: kind 0 writes sample_value at (row, col),
//   kind 1 asks for the bilinear value at world point (query_x, query_y).
//   o_result carries one beat per query (interp_value, inside_res); writes
//   give no beat. Points outside the span of pixel centers give zero with
//   inside_res low.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
//   must do so only while the block is idle, which the block does not enforce.
//   Sizes use the low 7 bits of i_cfg_data and are saturated to [2, 64].
// Throughput: one beat per cycle unless stalled; writes and queries freely mixed.
// Pipeline: a query passes three stages of axis mapping (subtract, 32x32
//   multiply, bounds check), one registered bank read, then weights, products,
//   pair sums and the output register. A write lands in the bank at the read
//   stage, so later queries see it in order.
// Reset clears the pipeline valid bits and sets the configuration registers to
//   their defaults; the sample store holds garbage until written.
// Stall: when the output register holds a beat that is not taken, the whole
//   pipeline freezes and i_query.ready drops; nothing is lost or repeated.
module grid_bilinear_interpolator_core
    import gbi_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    gbi_in_if.sink       i_query,
    gbi_out_if.source    o_result,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    localparam int QD = 7;  // query valid stages before the output register
    localparam int ID = 4;  // span flag stages from the bank read to the pair sums

    logic signed [31:0] r_x_origin, r_y_origin;
    logic [31:0]        r_x_scale, r_y_scale;
    logic [CNT_W-1:0]   r_cols, r_rows;
    logic [CNT_W-1:0]   ncols, nrows;

    logic               en;
    logic               acc_in;

    // write beats ride along to the bank-write stage
    logic [2:0]         r_wv;
    logic [ROW_W-1:0]   r_wrow [3];
    logic [COL_W-1:0]   r_wcol [3];
    logic [31:0]        r_wdat [3];

    logic [QD-1:0]      r_qv;
    logic [ID:1]        r_in;   // span flag from stage 4 on
    t_axis              ax_x, ax_y;
    logic               r4_rpar, r4_cpar;
    logic [15:0]        r4_fx, r4_fy;
    logic [31:0]        bank [BANK_N];
    logic signed [31:0] blend;

    logic               r_ov;
    logic signed [31:0] r_oval;
    logic               r_oin;

    always_comb begin
        ncols = (r_cols < CNT_W'(2)) ? CNT_W'(2) :
                (r_cols > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : r_cols;
        nrows = (r_rows < CNT_W'(2)) ? CNT_W'(2) :
                (r_rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : r_rows;
    end

    // the pipeline advances whenever the output slot is free or drains
    assign en              = !r_ov || o_result.ready;
    assign i_query.ready   = en;
    assign acc_in          = i_query.valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_y_origin <= '0;
            r_x_scale  <= 32'h0001_0000;
            r_y_scale  <= 32'h0001_0000;
            r_cols     <= CNT_W'(64);
            r_rows     <= CNT_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_ORIGIN: r_x_origin <= i_cfg_data;
                CFG_Y_ORIGIN: r_y_origin <= i_cfg_data;
                CFG_X_SCALE:  r_x_scale  <= i_cfg_data;
                CFG_Y_SCALE:  r_y_scale  <= i_cfg_data;
                CFG_COLS:     r_cols     <= i_cfg_data[CNT_W-1:0];
                CFG_ROWS:     r_rows     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= '0;
            r_qv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_wv <= {r_wv[1:0], acc_in && (i_query.kind == KIND_WRITE)};
            r_qv <= {r_qv[QD-2:0], acc_in && (i_query.kind == KIND_QUERY)};
            r_ov <= r_qv[QD-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wrow[0] <= i_query.row;
            r_wcol[0] <= i_query.col;
            r_wdat[0] <= i_query.sample_value;
            for (int k = 1; k < 3; k++) begin
                r_wrow[k] <= r_wrow[k-1];
                r_wcol[k] <= r_wcol[k-1];
                r_wdat[k] <= r_wdat[k-1];
            end
            r4_rpar  <= ax_y.lo[0];
            r4_cpar  <= ax_x.lo[0];
            r4_fx    <= ax_x.frac;
            r4_fy    <= ax_y.frac;
            r_in[1]  <= ax_x.in_span && ax_y.in_span;
            for (int k = 2; k <= ID; k++) begin
                r_in[k] <= r_in[k-1];
            end
            r_oin    <= r_in[ID];
            r_oval   <= r_in[ID] ? blend : 32'sd0;
        end
    end

    gbi_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_q      (i_query.query_x),
        .i_origin (r_x_origin),
        .i_scale  (r_x_scale),
        .i_n      (ncols),
        .o_res    (ax_x)
    );

    gbi_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_q      (i_query.query_y),
        .i_origin (r_y_origin),
        .i_scale  (r_y_scale),
        .i_n      (nrows),
        .o_res    (ax_y)
    );

    gbi_store u_store (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r_wv[2]),
        .i_wrow  (r_wrow[2]),
        .i_wcol  (r_wcol[2]),
        .i_wdata (r_wdat[2]),
        .i_r0    (ax_y.lo[ROW_W-1:0]),
        .i_c0    (ax_x.lo[COL_W-1:0]),
        .o_rdata (bank)
    );

    gbi_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_bank  (bank),
        .i_rpar  (r4_rpar),
        .i_cpar  (r4_cpar),
        .i_fx    (r4_fx),
        .i_fy    (r4_fy),
        .o_value (blend)
    );

    assign o_result.valid        = r_ov;
    assign o_result.interp_value = r_oval;
    assign o_result.inside_res   = r_oin;
endmodule

>>> hw/rtl/gbi_checker.sv
// Port-level assertions for the grid bilinear interpolator, bound to the top.
`timescale 1ns / 1ps
module gbi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic        i_out_inside
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value))
        else $error("result payload changed while stalled");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_inside |-> i_out_value == 32'd0)
        else $error("outside result is not zero");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output slot");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result beat right after reset");
endmodule

bind grid_bilinear_interpolator_core gbi_checker u_gbi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_query.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_value  (o_result.interp_value),
    .i_out_inside (o_result.inside_res)
);
